// File: hdl/adc_pkg.sv
// ----------------------------------------------------------------------------
// adc_pkg: shared types and constants of the access decision cache
// Item layouts, command codes, audit kinds and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package adc_pkg;

  localparam int unsigned BUCKETS_DEF = 512;
  localparam int unsigned ENTRIES_DEF = 1024;

  // Command codes of an input item
  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Audit kinds of a result item
  localparam logic [1:0] AUDIT_NONE  = 2'd0;
  localparam logic [1:0] AUDIT_GRANT = 2'd1;
  localparam logic [1:0] AUDIT_DENY  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] subject_id;
    logic [31:0] object_id;
    logic [15:0] object_class;
    logic [31:0] requested_perms;
    logic [31:0] allowed_perms;
    logic [31:0] decided_perms;
    logic [31:0] audit_allow_mask;
    logic [31:0] audit_deny_mask;
    logic [31:0] created_context_id;
  } adc_in_item_t;

  typedef struct packed {
    logic        hit;
    logic        access_granted;
    logic [31:0] denied_perms;
    logic [31:0] audited_perms;
    logic [1:0]  audit_kind;
    logic [31:0] new_context_id;
  } adc_out_item_t;

  // One stored decision entry
  typedef struct packed {
    logic [31:0] subject;
    logic [31:0] object;
    logic [15:0] cls;
    logic [31:0] allowed;
    logic [31:0] decided;
    logic [31:0] audit_deny;
    logic [31:0] audit_allow;
    logic [31:0] created;
  } adc_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic head_rd;
    logic head_ld;
    logic ent_rd;
    logic ent_step;
    logic set_hit;
    logic sw_start;
    logic sw_head_rd;
    logic sw_head_ld;
    logic sw_rd;
    logic sw_eval;
    logic sw_fix;
    logic sw_next;
    logic alloc_rd;
    logic alloc_wr;
    logic out_load;
  } adc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hash_done;
    logic clr_last;
    logic head_nil;
    logic link_nil;
    logic cur_nil;
    logic match;
    logic is_check;
    logic is_insert;
    logic is_flush;
    logic free_nil;
    logic sw_hot;
    logic prev_nil;
    logic sw_stop;
    logic out_free;
  } adc_sts_t;

endpackage

`default_nettype wire

// File: hdl/adc_stream_if.sv
// ----------------------------------------------------------------------------
// adc_stream_if: valid/ready channels of the access decision cache
// One interface for the request items and one for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface adc_in_if;
  import adc_pkg::*;
  logic         valid;
  logic         ready;
  adc_in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface adc_out_if;
  import adc_pkg::*;
  logic          valid;
  logic          ready;
  adc_out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/adc_ram.sv
// ----------------------------------------------------------------------------
// adc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/adc_ctrl.sv
// ----------------------------------------------------------------------------
// adc_ctrl: sequencing state machine of the access decision cache
// Steps the clearing pass, the chain walk, the clock sweep and allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ctrl
  import adc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire adc_sts_t sts,
  output adc_cmd_t      cmd
);

  typedef enum logic [15:0] {
    S_CLEAR       = 16'h0001,
    S_IDLE        = 16'h0002,
    S_HASH        = 16'h0004,
    S_HEAD_RD     = 16'h0008,
    S_HEAD_LD     = 16'h0010,
    S_ENT_RD      = 16'h0020,
    S_ENT_CMP     = 16'h0040,
    S_SW_HEAD_RD  = 16'h0080,
    S_SW_HEAD_LD  = 16'h0100,
    S_SW_RD       = 16'h0200,
    S_SW_EVAL     = 16'h0400,
    S_SW_FIX      = 16'h0800,
    S_SW_NEXT     = 16'h1000,
    S_ALLOC_RD    = 16'h2000,
    S_ALLOC_WR    = 16'h4000,
    S_DONE        = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   flush_r, flush_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = flush_r ? S_DONE : S_IDLE;
          flush_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.is_flush) begin
          flush_nxt = 1'b1;
          state_nxt = S_CLEAR;
        end else if (!sts.is_check && !sts.is_insert) begin
          state_nxt = S_DONE;
        end else if (sts.hash_done) begin
          state_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEAD_LD;
      end
      S_HEAD_LD: begin
        cmd.head_ld = 1'b1;
        if (!sts.head_nil) begin
          state_nxt = S_ENT_RD;
        end else if (!sts.is_insert) begin
          state_nxt = S_DONE;
        end else if (sts.free_nil) begin
          cmd.sw_start = 1'b1;
          state_nxt    = S_SW_HEAD_RD;
        end else begin
          state_nxt = S_ALLOC_RD;
        end
      end
      S_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = S_ENT_CMP;
      end
      S_ENT_CMP: begin
        if (sts.match) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.ent_step = 1'b1;
          if (!sts.link_nil) begin
            state_nxt = S_ENT_RD;
          end else if (!sts.is_insert) begin
            state_nxt = S_DONE;
          end else if (sts.free_nil) begin
            cmd.sw_start = 1'b1;
            state_nxt    = S_SW_HEAD_RD;
          end else begin
            state_nxt = S_ALLOC_RD;
          end
        end
      end
      S_SW_HEAD_RD: begin
        cmd.sw_head_rd = 1'b1;
        state_nxt      = S_SW_HEAD_LD;
      end
      S_SW_HEAD_LD: begin
        cmd.sw_head_ld = 1'b1;
        state_nxt      = sts.head_nil ? S_SW_NEXT : S_SW_RD;
      end
      S_SW_RD: begin
        cmd.sw_rd = 1'b1;
        state_nxt = S_SW_EVAL;
      end
      S_SW_EVAL: begin
        cmd.sw_eval = 1'b1;
        if (!sts.sw_hot && !sts.prev_nil) begin
          state_nxt = S_SW_FIX;
        end else begin
          state_nxt = sts.link_nil ? S_SW_NEXT : S_SW_RD;
        end
      end
      S_SW_FIX: begin
        cmd.sw_fix = 1'b1;
        state_nxt  = sts.cur_nil ? S_SW_NEXT : S_SW_RD;
      end
      S_SW_NEXT: begin
        cmd.sw_next = 1'b1;
        if (!sts.sw_stop) begin
          state_nxt = S_SW_HEAD_RD;
        end else begin
          state_nxt = sts.free_nil ? S_DONE : S_ALLOC_RD;
        end
      end
      S_ALLOC_RD: begin
        cmd.alloc_rd = 1'b1;
        state_nxt    = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/adc_datapath.sv
// ----------------------------------------------------------------------------
// adc_datapath: stores, pointers and result logic of the access decision cache
// Holds the bucket, link, hot and entry RAMs and the walk/sweep pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_datapath
  import adc_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire adc_cmd_t      cmd,
  output adc_sts_t           sts,
  input  wire adc_in_item_t  in_payload,
  input  wire logic          enforcing,
  input  wire logic          out_ready,
  output logic               out_valid,
  output adc_out_item_t      out_payload
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned LW   = IW + 1;
  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned MAXN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int unsigned CW   = $clog2(MAXN);
  localparam int unsigned RLIM = 2 * BUCKETS + 2;
  localparam int unsigned RW   = $clog2(RLIM + 1);
  localparam bit          POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [LW-1:0] NIL = {LW{1'b1}};
  // Reciprocal of BUCKETS, scaled so that the quotient estimate is low by at most one
  localparam int unsigned RSH   = 31 + BW;
  localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / 64'(BUCKETS));

  adc_in_item_t  item_r;
  logic [1:0]    hcnt_r;
  logic [BW-1:0] rem_r;
  logic [31:0]   quo_r, rest_r;
  logic [LW-1:0] cur_r, prev_r, free_r;
  logic [BW-1:0] hand_r;
  logic [RW-1:0] rounds_r;
  logic [CW-1:0] clr_cnt_r;
  logic          hit_r;
  logic          out_valid_r;
  adc_out_item_t out_r;

  // Hash and bucket index: multiply by the reciprocal, multiply back and
  // subtract, then one correcting subtract, each step registered
  logic [31:0]   hash;
  logic [63:0]   prod;
  logic [BW-1:0] bucket_idx;

  assign hash = item_r.subject_id ^ {item_r.object_id[29:0], 2'b00}
              ^ {16'h0000, item_r.object_class};
  assign prod = 64'(hash) * 64'(RECIP);
  assign bucket_idx = POW2 ? hash[BW-1:0] : rem_r;

  // RAM ports
  logic              bk_we, bk_re;
  logic [BW-1:0]     bk_waddr, bk_raddr;
  logic [LW-1:0]     bk_wdata, bk_rdata;
  logic              ln_we, ln_re;
  logic [IW-1:0]     ln_waddr, ln_raddr;
  logic [LW-1:0]     ln_wdata, ln_rdata;
  logic              hot_we, hot_wdata, hot_rdata;
  logic [IW-1:0]     hot_waddr;
  adc_entry_t        ent_wdata, ent_rdata;
  logic              clr_bk, clr_ln;

  assign clr_bk = cmd.clr_wr && ({1'b0, clr_cnt_r} < (CW+1)'(BUCKETS));
  assign clr_ln = cmd.clr_wr && ({1'b0, clr_cnt_r} < (CW+1)'(ENTRIES));

  always_comb begin
    bk_we    = 1'b0;
    bk_waddr = bucket_idx;
    bk_wdata = free_r;
    priority if (clr_bk) begin
      bk_we    = 1'b1;
      bk_waddr = clr_cnt_r[BW-1:0];
      bk_wdata = NIL;
    end else if (cmd.sw_eval && !hot_rdata && prev_r[IW]) begin
      bk_we    = 1'b1;
      bk_waddr = hand_r;
      bk_wdata = ln_rdata;
    end else if (cmd.alloc_wr) begin
      bk_we = 1'b1;
    end else begin
      bk_we = 1'b0;
    end
  end

  assign bk_re    = cmd.head_rd || cmd.alloc_rd || cmd.sw_head_rd;
  assign bk_raddr = cmd.sw_head_rd ? hand_r : bucket_idx;

  always_comb begin
    ln_we    = 1'b0;
    ln_waddr = free_r[IW-1:0];
    ln_wdata = bk_rdata;
    priority if (clr_ln) begin
      ln_we    = 1'b1;
      ln_waddr = clr_cnt_r[IW-1:0];
      ln_wdata = (clr_cnt_r == '0) ? NIL : LW'(clr_cnt_r - CW'(1));
    end else if (cmd.sw_eval && !hot_rdata) begin
      ln_we    = 1'b1;
      ln_waddr = cur_r[IW-1:0];
      ln_wdata = free_r;
    end else if (cmd.sw_fix) begin
      ln_we    = 1'b1;
      ln_waddr = prev_r[IW-1:0];
      ln_wdata = cur_r;
    end else if (cmd.alloc_wr) begin
      ln_we = 1'b1;
    end else begin
      ln_we = 1'b0;
    end
  end

  assign ln_re    = cmd.ent_rd || cmd.sw_rd || cmd.alloc_rd;
  assign ln_raddr = cmd.alloc_rd ? free_r[IW-1:0] : cur_r[IW-1:0];

  always_comb begin
    hot_we    = 1'b0;
    hot_waddr = cur_r[IW-1:0];
    hot_wdata = 1'b0;
    priority if (clr_ln) begin
      hot_we    = 1'b1;
      hot_waddr = clr_cnt_r[IW-1:0];
    end else if (cmd.sw_eval && hot_rdata) begin
      hot_we = 1'b1;
    end else if (cmd.alloc_wr) begin
      hot_we    = 1'b1;
      hot_waddr = free_r[IW-1:0];
      hot_wdata = 1'b1;
    end else begin
      hot_we = 1'b0;
    end
  end

  assign ent_wdata.subject     = item_r.subject_id;
  assign ent_wdata.object      = item_r.object_id;
  assign ent_wdata.cls         = item_r.object_class;
  assign ent_wdata.allowed     = item_r.allowed_perms;
  assign ent_wdata.decided     = item_r.decided_perms;
  assign ent_wdata.audit_deny  = item_r.audit_deny_mask;
  assign ent_wdata.audit_allow = item_r.audit_allow_mask;
  assign ent_wdata.created     = item_r.created_context_id;

  adc_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .re(bk_re), .raddr(bk_raddr), .rdata(bk_rdata)
  );

  adc_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .re(ln_re), .raddr(ln_raddr), .rdata(ln_rdata)
  );

  adc_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_hot_ram (
    .clk(clk), .we(hot_we), .waddr(hot_waddr), .wdata(hot_wdata),
    .re(cmd.sw_rd), .raddr(cur_r[IW-1:0]), .rdata(hot_rdata)
  );

  adc_ram #(.WIDTH($bits(adc_entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
    .clk(clk), .we(cmd.alloc_wr), .waddr(free_r[IW-1:0]), .wdata(ent_wdata),
    .re(cmd.ent_rd), .raddr(cur_r[IW-1:0]), .rdata(ent_rdata)
  );

  // Entry match and check result
  logic          is_check, is_insert, is_flush;
  logic [31:0]   perms, denied, audited;
  adc_out_item_t res;

  assign is_check  = (item_r.command == CMD_CHECK);
  assign is_insert = (item_r.command == CMD_INSERT);
  assign is_flush  = (item_r.command == CMD_FLUSH);
  assign perms     = is_check ? item_r.requested_perms : item_r.decided_perms;
  assign denied    = item_r.requested_perms & ~ent_rdata.allowed;
  assign audited   = (denied != '0) ? (denied & ent_rdata.audit_deny)
                                    : (item_r.requested_perms & ent_rdata.audit_allow);

  always_comb begin
    res     = '0;
    res.hit = hit_r;
    if (is_check && hit_r) begin
      res.access_granted = !(enforcing &&
                             ((item_r.requested_perms == '0) || (denied != '0)));
      res.denied_perms   = denied;
      res.audited_perms  = audited;
      res.audit_kind     = (audited == '0) ? AUDIT_NONE
                         : ((denied != '0) ? AUDIT_DENY : AUDIT_GRANT);
      res.new_context_id = ent_rdata.created;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_payload;
    end
    if (cmd.out_load) begin
      out_r <= res;
    end
    quo_r  <= 32'(prod >> RSH);
    rest_r <= hash - (quo_r * 32'(BUCKETS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r      <= '0;
      rem_r       <= '0;
      cur_r       <= NIL;
      prev_r      <= NIL;
      free_r      <= NIL;
      hand_r      <= '0;
      rounds_r    <= '0;
      clr_cnt_r   <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        hcnt_r <= '0;
        hit_r  <= 1'b0;
      end else if (hcnt_r != 2'd2) begin
        hcnt_r <= hcnt_r + 2'd1;
      end
      rem_r <= (rest_r >= 32'(BUCKETS)) ? BW'(rest_r - 32'(BUCKETS)) : BW'(rest_r);
      if (cmd.set_hit) begin
        hit_r <= 1'b1;
      end
      // Clearing pass: rebuild the free list and park the hand at zero
      if (cmd.clr_wr) begin
        if (clr_cnt_r == CW'(MAXN - 1)) begin
          clr_cnt_r <= '0;
          free_r    <= LW'(ENTRIES - 1);
          hand_r    <= '0;
        end else begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
        end
      end
      if (cmd.head_ld || cmd.sw_head_ld) begin
        cur_r  <= bk_rdata;
        prev_r <= NIL;
      end
      if (cmd.ent_step) begin
        cur_r <= ln_rdata;
      end
      if (cmd.sw_eval) begin
        cur_r <= ln_rdata;
        if (hot_rdata) begin
          prev_r <= cur_r;
        end else begin
          free_r <= cur_r;
        end
      end
      if (cmd.sw_start) begin
        rounds_r <= '0;
      end
      if (cmd.sw_next) begin
        rounds_r <= rounds_r + RW'(1);
        hand_r   <= (hand_r == BW'(BUCKETS - 1)) ? '0 : hand_r + BW'(1);
      end
      if (cmd.alloc_wr) begin
        free_r <= ln_rdata;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.hash_done = POW2 || (hcnt_r == 2'd2);
  assign sts.clr_last  = (clr_cnt_r == CW'(MAXN - 1));
  assign sts.head_nil  = bk_rdata[IW];
  assign sts.link_nil  = ln_rdata[IW];
  assign sts.cur_nil   = cur_r[IW];
  assign sts.match     = (ent_rdata.subject == item_r.subject_id)
                      && (ent_rdata.object == item_r.object_id)
                      && (ent_rdata.cls == item_r.object_class)
                      && ((perms & ent_rdata.decided) == perms);
  assign sts.is_check  = is_check;
  assign sts.is_insert = is_insert;
  assign sts.is_flush  = is_flush;
  assign sts.free_nil  = free_r[IW];
  assign sts.sw_hot    = hot_rdata;
  assign sts.prev_nil  = prev_r[IW];
  assign sts.sw_stop   = !free_r[IW] || (rounds_r == RW'(RLIM - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

// File: hdl/access_decision_cache.sv
// ----------------------------------------------------------------------------
// access_decision_cache: hashed, chained cache of access decisions
// Check, insert and flush items in; one result item out per request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A check or insert hashes the key, reads
// the bucket head and walks the chain entry by entry until a match or its end
// (with a reciprocal multiply reduction of the hash when BUCKETS is not a power
// of two). An insert that misses allocates an entry, and if no entry is free
// it first runs a clock sweep, bucket by bucket, over the entries in each.
// A flush, and reset, run a clearing pass over max(BUCKETS, ENTRIES) addresses
// of the bucket, link and hot RAMs, during which no item is taken;
// configuration writes are taken at any time. The
// result sits in an output register, so the next item may enter while a
// result waits. Register 0 (byte address 0) holds the enforcing bit.
// ----------------------------------------------------------------------------
`default_nettype none

module access_decision_cache
  import adc_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  adc_in_if.sink           in_ch,
  adc_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  adc_cmd_t cmd;
  adc_sts_t sts;
  logic     enforcing_r;

  // Configuration: one register, so every address decodes to it
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'h0, enforcing_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enforcing_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr == 2'b00 || cfg_paddr != 2'b00)) begin
      enforcing_r <= cfg_pwdata[0];
    end
  end

  // Sequence the walk and sweep
  adc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the stores, pointers and the output register
  adc_datapath #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_payload  (in_ch.payload),
    .enforcing   (enforcing_r),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_payload (out_ch.payload)
  );

endmodule

`default_nettype wire

// File: hdl/adc_checker.sv
// ----------------------------------------------------------------------------
// adc_checker: port-level checks of the access decision cache
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_checker
  import adc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        hit,
  input wire logic        access_granted,
  input wire logic [31:0] denied_perms,
  input wire logic [31:0] audited_perms,
  input wire logic [1:0]  audit_kind,
  input wire logic [31:0] new_context_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_context_id))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> !access_granted && denied_perms == 32'h0
      && audited_perms == 32'h0 && audit_kind == AUDIT_NONE && new_context_id == 32'h0)
    else $error("miss result carries data");

  a_audit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && audit_kind == AUDIT_DENY |-> denied_perms != 32'h0
      && audited_perms != 32'h0)
    else $error("denial audited without denied bits");

  a_kind_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && audited_perms == 32'h0 |-> audit_kind == AUDIT_NONE)
    else $error("audit kind set with nothing audited");

endmodule

bind access_decision_cache adc_checker u_adc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .hit            (out_ch.payload.hit),
  .access_granted (out_ch.payload.access_granted),
  .denied_perms   (out_ch.payload.denied_perms),
  .audited_perms  (out_ch.payload.audited_perms),
  .audit_kind     (out_ch.payload.audit_kind),
  .new_context_id (out_ch.payload.new_context_id)
);

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the access decision cache
// Drives check, insert and flush items through the valid/ready channels and
// writes the enforcing register over the APB port. A model of the hashed,
// chained store predicts every result item, which is then compared field by
// field as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import adc_pkg::*;

  localparam int NBKT      = 512;
  localparam int NENT      = 1024;
  localparam int NONE      = -1;
  localparam int STALL_MAX = 50000;
  localparam logic [1:0] REG_ENFORCING = 2'd0;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  adc_in_if  in_ch ();
  adc_out_if out_ch ();

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
  end

  access_decision_cache i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Decision store model: bucket chains, free list, clock hand, hot marks
  // --------------------------------------------------------------------------
  int            chain_head [NBKT];
  int            chain_link [NENT];
  bit            hot_mark   [NENT];
  adc_entry_t    store      [NENT];
  int            free_top;
  int            hand;
  bit            enforce_on;
  adc_out_item_t pending_results [$];

  function automatic void wipe_store();
    for (int i = 0; i < NBKT; i++) chain_head[i] = NONE;
    for (int i = 0; i < NENT; i++) begin
      chain_link[i] = (i == 0) ? NONE : i - 1;
      hot_mark[i]   = 1'b0;
    end
    free_top = NENT - 1;
    hand     = 0;
  endfunction

  function automatic int bucket_index(logic [31:0] s, logic [31:0] o, logic [15:0] c);
    logic [31:0] h;
    h = s ^ (o << 2) ^ {16'd0, c};
    return int'(h % NBKT);
  endfunction

  function automatic int lookup(logic [31:0] s, logic [31:0] o, logic [15:0] c,
                                logic [31:0] perms);
    int cur;
    cur = chain_head[bucket_index(s, o, c)];
    while (cur != NONE) begin
      if (store[cur].subject == s && store[cur].object == o && store[cur].cls == c &&
          (perms & store[cur].decided) == perms)
        return cur;
      cur = chain_link[cur];
    end
    return NONE;
  endfunction

  // Clock sweep: clear hot marks, release cold entries until one is free
  function automatic void reclaim();
    int rounds, b, prv, cur, nxt;
    rounds = 0;
    while (free_top == NONE && rounds < 2 * NBKT + 2) begin
      b   = hand % NBKT;
      prv = NONE;
      cur = chain_head[b];
      while (cur != NONE) begin
        nxt = chain_link[cur];
        if (hot_mark[cur]) begin
          hot_mark[cur] = 1'b0;
          prv = cur;
        end else begin
          if (prv != NONE) chain_link[prv] = nxt;
          else chain_head[b] = nxt;
          chain_link[cur] = free_top;
          free_top = cur;
        end
        cur = nxt;
      end
      hand = (b + 1) % NBKT;
      rounds++;
    end
  endfunction

  function automatic adc_out_item_t decide(adc_in_item_t it);
    adc_out_item_t r;
    int e, b;
    logic [31:0] den, aud;
    r = '0;
    case (it.command)
      CMD_CHECK: begin
        e = lookup(it.subject_id, it.object_id, it.object_class, it.requested_perms);
        if (e != NONE) begin
          den = it.requested_perms & ~store[e].allowed;
          aud = (den != 0) ? (den & store[e].audit_deny)
                           : (it.requested_perms & store[e].audit_allow);
          r.hit            = 1'b1;
          r.access_granted = !(enforce_on && (it.requested_perms == 0 || den != 0));
          r.denied_perms   = den;
          r.audited_perms  = aud;
          r.audit_kind     = (aud == 0) ? AUDIT_NONE : (den != 0 ? AUDIT_DENY : AUDIT_GRANT);
          r.new_context_id = store[e].created;
        end
      end
      CMD_INSERT: begin
        e = lookup(it.subject_id, it.object_id, it.object_class, it.decided_perms);
        if (e != NONE) begin
          r.hit = 1'b1;
        end else begin
          if (free_top == NONE) reclaim();
          if (free_top != NONE) begin
            e        = free_top;
            free_top = chain_link[e];
            store[e].subject     = it.subject_id;
            store[e].object      = it.object_id;
            store[e].cls         = it.object_class;
            store[e].allowed     = it.allowed_perms;
            store[e].decided     = it.decided_perms;
            store[e].audit_allow = it.audit_allow_mask;
            store[e].audit_deny  = it.audit_deny_mask;
            store[e].created     = it.created_context_id;
            hot_mark[e]   = 1'b1;
            b             = bucket_index(it.subject_id, it.object_id, it.object_class);
            chain_link[e] = chain_head[b];
            chain_head[b] = e;
          end
        end
      end
      CMD_FLUSH: wipe_store();
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: sample at the falling edge, before the next rising one
  // --------------------------------------------------------------------------
  int mismatches = 0;
  int quiet_cycles = 0;

  always @(negedge clk) begin
    adc_out_item_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.access_granted !== want.access_granted ||
            got.denied_perms !== want.denied_perms ||
            got.audited_perms !== want.audited_perms ||
            got.audit_kind !== want.audit_kind ||
            got.new_context_id !== want.new_context_id) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog: count cycles in which no item moves on either channel
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  int sink_idle_pct = 0;
  bit hold_off_req = 1'b0;

  always @(posedge clk) begin
    if (hold_off_req) begin
      out_ch.ready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_off_req = 1'b0;
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int src_idle_pct = 0;

  // Offer one item; predict its result when the block accepts it
  task automatic offer(adc_in_item_t it, bit has_fixed, adc_out_item_t fixed);
    adc_out_item_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
      @(posedge clk);
    end
    r = decide(it);
    if (has_fixed && r !== fixed) begin
      mismatches++;
      if (mismatches <= 10) $display("model disagrees with table: %p vs %p", r, fixed);
    end
    pending_results.push_back(r);
    @(posedge clk);
  endtask

  // Hold the channel empty until every result is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_enforcing(bit v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ENFORCING;
    cfg_pwdata  <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (cfg_pready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    enforce_on = v;
  endtask

  // Recently inserted items: reused by checks and duplicate inserts
  adc_in_item_t recent [$];

  function automatic adc_in_item_t random_item(bit fill_only);
    adc_in_item_t it, k;
    int roll;
    it.command            = CMD_CHECK;
    it.subject_id         = $urandom;
    it.object_id          = $urandom;
    it.object_class       = $urandom;
    it.requested_perms    = $urandom;
    it.allowed_perms      = $urandom;
    it.decided_perms      = $urandom;
    it.audit_allow_mask   = $urandom;
    it.audit_deny_mask    = $urandom;
    it.created_context_id = $urandom;
    roll = $urandom_range(99);
    if (fill_only) begin
      it.command = CMD_INSERT;
    end else if (roll < 2) begin
      it.command = ($urandom_range(1) != 0) ? CMD_FLUSH : CMD_UNUSED;
    end else if (roll < 40 || recent.size() == 0) begin
      it.command = CMD_INSERT;
      // share a bucket with an earlier key now and then to grow chains
      if (recent.size() != 0 && $urandom_range(2) == 0) begin
        k = recent[$urandom_range(recent.size() - 1)];
        it.subject_id = k.subject_id ^ {$urandom_range(7), 9'd0};
        it.object_id  = k.object_id;
        it.object_class = k.object_class;
      end
    end else begin
      k = recent[$urandom_range(recent.size() - 1)];
      it.subject_id   = k.subject_id;
      it.object_id    = k.object_id;
      it.object_class = k.object_class;
      case ($urandom_range(3))
        0: it.requested_perms = k.decided_perms & $urandom;
        1: it.requested_perms = k.decided_perms & k.allowed_perms & $urandom;
        2: begin
          it.command = CMD_INSERT;
          it.decided_perms = k.decided_perms & $urandom;
        end
        default: ;
      endcase
    end
    if (it.command == CMD_INSERT) begin
      recent.push_back(it);
      if (recent.size() > 24) void'(recent.pop_front());
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    adc_in_item_t  it;
    bit            has_fixed;
    adc_out_item_t fixed;
  } stim_row_t;

  function automatic adc_in_item_t mk(logic [1:0] c, logic [31:0] s, logic [31:0] o,
                                      logic [15:0] k, logic [31:0] req, logic [31:0] alw,
                                      logic [31:0] dec, logic [31:0] aa, logic [31:0] ad,
                                      logic [31:0] cc);
    adc_in_item_t it;
    it = '{c, s, o, k, req, alw, dec, aa, ad, cc};
    return it;
  endfunction

  function automatic adc_out_item_t res(logic h, logic g, logic [31:0] d, logic [31:0] a,
                                        logic [1:0] ak, logic [31:0] nc);
    adc_out_item_t r;
    r = '{h, g, d, a, ak, nc};
    return r;
  endfunction

  stim_row_t table_rows [$];

  task automatic build_table();
    adc_out_item_t z;
    z = '0;
    // miss on an empty store
    table_rows.push_back('{mk(CMD_CHECK, 1, 2, 3, 32'hF, 0, 0, 0, 0, 0), 1'b1, z});
    // all-ones entry; an exact duplicate then hits
    table_rows.push_back('{mk(CMD_INSERT, '1, '1, '1, 0, '1, '1, '1, '1, '1), 1'b1, z});
    table_rows.push_back('{mk(CMD_INSERT, '1, '1, '1, 0, '1, '1, '1, '1, '1), 1'b1,
                           res(1, 0, 0, 0, AUDIT_NONE, 0)});
    table_rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1, 0, 0, 0, 0, 0), 1'b1,
                           res(1, 1, 0, '1, AUDIT_GRANT, '1)});
    // nothing requested: refused while enforcing
    table_rows.push_back('{mk(CMD_CHECK, '1, '1, '1, 0, 0, 0, 0, 0, 0), 1'b1,
                           res(1, 0, 0, 0, AUDIT_NONE, '1)});
    // all-zero key entry, nothing allowed: denial audited
    table_rows.push_back('{mk(CMD_INSERT, 0, 0, 0, 0, 0, '1, 0, '1, 32'h5A5A5A5A), 1'b1, z});
    table_rows.push_back('{mk(CMD_CHECK, 0, 0, 0, 32'h80000001, 0, 0, 0, 0, 0), 1'b1,
                           res(1, 0, 32'h80000001, 32'h80000001, AUDIT_DENY, 32'h5A5A5A5A)});
    // partly allowed entry in a shared bucket
    table_rows.push_back('{mk(CMD_INSERT, 32'h200, 0, 0, 0, 32'h0000FFFF, 32'h00FFFFFF,
                              32'h00000F0F, 32'h00F00000, 32'h1234), 1'b0, z});
    table_rows.push_back('{mk(CMD_CHECK, 32'h200, 0, 0, 32'h000000FF, 0, 0, 0, 0, 0), 1'b0, z});
    table_rows.push_back('{mk(CMD_CHECK, 32'h200, 0, 0, 32'h00F000FF, 0, 0, 0, 0, 0), 1'b0, z});
    table_rows.push_back('{mk(CMD_CHECK, 32'h200, 0, 0, 32'h000F0000, 0, 0, 0, 0, 0), 1'b0, z});
    // decided mask does not cover the request: miss
    table_rows.push_back('{mk(CMD_CHECK, 32'h200, 0, 0, 32'h01000000, 0, 0, 0, 0, 0), 1'b1, z});
    table_rows.push_back('{mk(CMD_CHECK, 32'h200, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
    // unused command code and flush both leave zero results
    table_rows.push_back('{mk(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, z});
    table_rows.push_back('{mk(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
    table_rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1, 0, 0, 0, 0, 0), 1'b1, z});
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    wipe_store();
    enforce_on = 1'b1;
    build_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) offer(table_rows[i].it, table_rows[i].has_fixed, table_rows[i].fixed);
    drain();

    // phase 1: sparse sender, busy receiver, reporting only
    write_enforcing(1'b0);
    src_idle_pct  = 32;
    sink_idle_pct = 86;
    repeat (200) offer(random_item(1'b0), 1'b0, '0);
    drain();

    // phase 2: the other way round, enforcing; one long hold-off midway
    write_enforcing(1'b1);
    src_idle_pct  = 86;
    sink_idle_pct = 32;
    repeat (90) offer(random_item(1'b0), 1'b0, '0);
    src_idle_pct = 0;
    hold_off_req = 1'b1;
    repeat (40) offer(random_item(1'b0), 1'b0, '0);
    src_idle_pct = 86;
    repeat (90) offer(random_item(1'b0), 1'b0, '0);
    drain();

    // phase 3: no idling; load the store with inserts, then mixed traffic
    write_enforcing(1'b0);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    offer(mk(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    repeat (200) offer(random_item(1'b1), 1'b0, '0);
    drain();
    write_enforcing(1'b1);
    repeat (110) offer(random_item(1'b0), 1'b0, '0);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
